[hdl/lfgs_pkg.sv]
// Shared constants and command types for the life grid generation step block.
package lfgs_pkg;

    localparam int ROW_W          = 8;
    localparam int ROW_NUM_W      = 3;
    localparam int GRID_ROWS_DEF  = 8;
    localparam int GRID_COLS_DEF  = 8;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic                 emit;
        logic                 last;
        logic [ROW_NUM_W-1:0] emit_num;
    } t_ctrl_cmd;

endpackage

[hdl/lfgs_datapath.sv]
// Row store, three-row window and neighbor-count logic for the life generation step.
module lfgs_datapath #(
    parameter int GRID_ROWS = lfgs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lfgs_pkg::GRID_COLS_DEF,
    parameter int ADDR_W    = $clog2(GRID_ROWS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lfgs_pkg::t_ctrl_cmd              i_cmd,
    input  logic [ADDR_W-1:0]                i_wr_addr,
    input  logic [ADDR_W-1:0]                i_rd_addr,
    input  logic [lfgs_pkg::ROW_W-1:0]       i_row_cells,
    output logic                             o_valid,
    output logic [lfgs_pkg::ROW_W-1:0]       o_next_row_cells,
    output logic [lfgs_pkg::ROW_NUM_W-1:0]   o_row_number,
    output logic                             o_last_row
);

    localparam int RW = lfgs_pkg::ROW_W;
    // Columns at or beyond the grid width are always dead.
    localparam logic [RW-1:0] COL_MASK =
        (GRID_COLS >= RW) ? {RW{1'b1}} : RW'((1 << GRID_COLS) - 1);

    logic [RW-1:0] r_grid [GRID_ROWS];
    logic [RW-1:0] r_rd_data;
    logic          r_rd_valid;
    logic [RW-1:0] r_upper;
    logic [RW-1:0] r_middle;
    logic [RW-1:0] incoming;
    logic [RW-1:0] n_cells;

    logic                              r_out_valid;
    logic [RW-1:0]                     r_out_cells;
    logic [lfgs_pkg::ROW_NUM_W-1:0]    r_out_num;
    logic                              r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_grid[i_wr_addr] <= i_row_cells & COL_MASK;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_grid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
        end
    end

    // A read past the bottom row brings in a dead row.
    assign incoming = r_rd_valid ? r_rd_data : '0;

    // The window slides every cycle; the controller times the reads so that
    // upper, middle and incoming hold the rows around the row being emitted.
    always_ff @(posedge i_clk) begin
        r_upper  <= r_middle;
        r_middle <= incoming;
    end

    always_comb begin
        logic [RW+1:0] pad_up;
        logic [RW+1:0] pad_mid;
        logic [RW+1:0] pad_dn;
        logic [3:0]    live_near;
        pad_up  = {1'b0, r_upper, 1'b0};
        pad_mid = {1'b0, r_middle, 1'b0};
        pad_dn  = {1'b0, incoming, 1'b0};
        n_cells = '0;
        for (int c = 0; c < RW; c++) begin
            live_near = 4'(pad_up[c]) + 4'(pad_up[c+1]) + 4'(pad_up[c+2])
                      + 4'(pad_mid[c]) + 4'(pad_mid[c+2])
                      + 4'(pad_dn[c]) + 4'(pad_dn[c+1]) + 4'(pad_dn[c+2]);
            n_cells[c] = (live_near == 4'd3) || ((live_near == 4'd2) && r_middle[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cells <= n_cells & COL_MASK;
        r_out_num   <= i_cmd.emit_num;
        r_out_last  <= i_cmd.last;
    end

    assign o_valid          = r_out_valid;
    assign o_next_row_cells = r_out_cells;
    assign o_row_number     = r_out_num;
    assign o_last_row       = r_out_last;

endmodule

[hdl/lfgs_ctrl.sv]
// Sequencer for loading grid rows and emitting the next generation row by row.
module lfgs_ctrl #(
    parameter int GRID_ROWS = lfgs_pkg::GRID_ROWS_DEF,
    parameter int ADDR_W    = $clog2(GRID_ROWS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output lfgs_pkg::t_ctrl_cmd  o_cmd,
    output logic [ADDR_W-1:0]    o_wr_addr,
    output logic [ADDR_W-1:0]    o_rd_addr
);

    localparam int PTR_W = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(GRID_ROWS - 1);
    localparam logic [PTR_W-1:0]  ROWS_PTR = PTR_W'(GRID_ROWS);

    localparam logic [1:0] S_LOAD   = 2'd0;
    localparam logic [1:0] S_PRIME0 = 2'd1;
    localparam logic [1:0] S_PRIME1 = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [ADDR_W-1:0]              r_count, n_count;
    logic [PTR_W-1:0]               r_rd_ptr, n_rd_ptr;
    logic [lfgs_pkg::ROW_NUM_W-1:0] r_emit_num, n_emit_num;
    logic                           ptr_in_grid;

    assign ptr_in_grid = (r_rd_ptr < ROWS_PTR);

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_rd_ptr        = r_rd_ptr;
        n_emit_num      = r_emit_num;
        o_cmd.wr_en     = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.last      = 1'b0;
        o_cmd.emit_num  = r_emit_num;
        busy            = 1'b1;
        case (r_state)
            S_LOAD: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.wr_en = 1'b1;
                    if (r_count == LAST_ROW) begin
                        n_count  = '0;
                        n_rd_ptr = '0;
                        n_state  = S_PRIME0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_PRIME0: begin
                o_cmd.rd_en = ptr_in_grid;
                n_rd_ptr    = r_rd_ptr + 1'b1;
                n_state     = S_PRIME1;
            end
            S_PRIME1: begin
                o_cmd.rd_en = ptr_in_grid;
                n_rd_ptr    = r_rd_ptr + 1'b1;
                n_emit_num  = '0;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.rd_en = ptr_in_grid;
                o_cmd.emit  = 1'b1;
                o_cmd.last  = (r_count == LAST_ROW);
                n_rd_ptr    = r_rd_ptr + 1'b1;
                if (r_count == LAST_ROW) begin
                    n_count = '0;
                    n_state = S_LOAD;
                end else begin
                    n_count    = r_count + 1'b1;
                    n_emit_num = r_emit_num + 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
                n_count = '0;
            end
        endcase
    end

    assign o_wr_addr = r_count;
    assign o_rd_addr = r_rd_ptr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_rd_ptr   <= '0;
            r_emit_num <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_ptr   <= n_rd_ptr;
            r_emit_num <= n_emit_num;
        end
    end

`ifndef SYNTHESIS
    a_last_emit_returns_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.last |=> r_state == S_LOAD)
        else $error("Controller did not return to loading after the last row.");

    a_final_load_starts_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && r_count == LAST_ROW |=> r_state == S_PRIME0 && r_rd_ptr == '0)
        else $error("Final row request did not start the generation pass.");

    a_no_read_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> !o_cmd.rd_en && !o_cmd.emit)
        else $error("Store read or emit while loading rows.");

    a_emit_rows_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && !o_cmd.last |=>
            o_cmd.emit && o_cmd.emit_num == $past(o_cmd.emit_num) + 3'd1)
        else $error("Emitted rows are not consecutive.");
`endif

endmodule

[hdl/life_grid_generation_step_top.sv]
// Top level of the bounded-grid life generation step block.
//
// Usage: present one grid row on i_row_cells with start high; the request is
// taken at a rising edge where start is high and busy is low, top row first.
// Taking the last row of the grid makes the block busy: the priming states
// S_PRIME0 and S_PRIME1 fill a three-row window from the row store, then one
// next-generation row per cycle leaves on o_next_row_cells with o_row_number
// and o_last_row, each marked by a one-cycle o_valid strobe, top row first.
// Each result row is registered before its strobe; busy falls in the cycle
// that the final row strobes, so a new grid may load right away.
// The single read port of the row store feeds the window one row per cycle.
// The receiver cannot stall; every strobe is a delivered result.
// Reset (synchronous, active low) returns to loading at the top row and drops
// any partial grid; the row store itself is not cleared.
module life_grid_generation_step_top #(
    parameter int GRID_ROWS = lfgs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lfgs_pkg::GRID_COLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lfgs_pkg::ROW_W-1:0]       i_row_cells,
    output logic                             o_valid,
    output logic [lfgs_pkg::ROW_W-1:0]       o_next_row_cells,
    output logic [lfgs_pkg::ROW_NUM_W-1:0]   o_row_number,
    output logic                             o_last_row
);

    localparam int ADDR_W = $clog2(GRID_ROWS);

    lfgs_pkg::t_ctrl_cmd cmd;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;

    lfgs_ctrl #(
        .GRID_ROWS (GRID_ROWS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_cmd     (cmd),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    lfgs_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .ADDR_W    (ADDR_W)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_wr_addr        (wr_addr),
        .i_rd_addr        (rd_addr),
        .i_row_cells      (i_row_cells),
        .o_valid          (o_valid),
        .o_next_row_cells (o_next_row_cells),
        .o_row_number     (o_row_number),
        .o_last_row       (o_last_row)
    );

endmodule
